FILE: sv/dbrm_pkg.sv
package dbrm_pkg;

  // Sizing defaults handed to the top level parameters
  localparam int MAX_SLOTS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // Ring size limits and register reset values
  localparam int MIN_RING_SIZE      = 2;
  localparam int RING_SIZE_W        = 5;
  localparam logic [RING_SIZE_W-1:0] RING_SIZE_RST = RING_SIZE_W'(MIN_RING_SIZE);

  // Fixed field widths on the streams
  localparam int FUNC_W      = 2;
  localparam int INDEX_W     = 4;
  localparam int TOTAL_W     = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_HALF = 2'd0,
    FUNC_DONE = 2'd1,
    FUNC_POP  = 2'd2,
    FUNC_FREE = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [INDEX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] next_fill_index;
    logic               pop_valid;
    logic [INDEX_W-1:0] pop_index;
    logic               drop_pending;
    logic               sequence_error;
    logic [TOTAL_W-1:0] dropped_total;
    logic [TOTAL_W-1:0] received_total;
  } result_t;

endpackage

FILE: sv/dbrm_in_stage.sv
module dbrm_in_stage import dbrm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic [FUNC_W-1:0]     s_user_i,
  input  logic [IN_TDATA_W-1:0] s_data_i,
  output logic                  s_ready_o,
  input  logic                  out_free_i,
  output req_t                  req_o,
  output logic                  fire_o
);

  logic valid_q;
  req_t req_q;

  // request moves on when the result register can take it
  assign fire_o    = valid_q && out_free_i;
  assign s_ready_o = !valid_q || out_free_i;
  assign req_o     = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_valid_i && s_ready_o) begin
      valid_q <= 1'b1;
    end else if (fire_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      req_q.func       <= func_e'(s_user_i);
      req_q.free_index <= s_data_i[INDEX_W-1:0];
    end
  end

endmodule

FILE: sv/dbrm_ring_core.sv
module dbrm_ring_core import dbrm_pkg::*; #(
  parameter int MaxSlots   = MAX_SLOTS_DEF,
  parameter int CountWidth = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  req_t                   req_i,
  input  logic                   fire_i,
  input  logic [RING_SIZE_W-1:0] ring_size_i,
  input  logic                   dual_channel_i,
  output result_t                res_o
);

  localparam int IdxW  = $clog2(MaxSlots);
  localparam int SzRaw = $clog2(MaxSlots + 1);
  localparam int SzW   = (SzRaw > RING_SIZE_W) ? SzRaw : RING_SIZE_W;
  localparam int OutW  = (IdxW > INDEX_W) ? IdxW : INDEX_W;
  localparam int CntW  = (CountWidth > TOTAL_W) ? CountWidth : TOTAL_W;

  logic [MaxSlots-1:0]   slot_full_q, slot_full_d;
  logic [IdxW-1:0]       fill_slot_q, fill_slot_d;
  logic [IdxW-1:0]       next_slot_q, next_slot_d;
  logic [IdxW-1:0]       read_slot_q, read_slot_d;
  logic                  decided_q, decided_d;
  logic                  drop_q, drop_d;
  logic                  first_done_q, first_done_d;
  logic [CountWidth-1:0] drop_cnt_q, drop_cnt_d;
  logic [CountWidth-1:0] recv_cnt_q, recv_cnt_d;

  logic [SzW-1:0]  ring_sz, eff_size, free_ext;
  logic [IdxW-1:0] after_fill, after_read;
  logic            set_en, free_en, pop_v, seq_err;
  logic [IdxW-1:0] pop_idx;
  logic [OutW-1:0] next_ext, pop_ext;
  logic [CntW-1:0] drop_ext, recv_ext;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] x,
                                              input logic [SzW-1:0]  sz);
    logic [SzW-1:0] y;
    y = SzW'(x) + SzW'(1);
    return (y >= sz) ? '0 : IdxW'(y);
  endfunction

  // ring size saturated to the supported range
  always_comb begin
    ring_sz = SzW'(ring_size_i);
    if (ring_sz < SzW'(MIN_RING_SIZE)) begin
      eff_size = SzW'(MIN_RING_SIZE);
    end else if (ring_sz > SzW'(MaxSlots)) begin
      eff_size = SzW'(MaxSlots);
    end else begin
      eff_size = ring_sz;
    end
  end

  assign after_fill = wrap_inc(fill_slot_q, eff_size);
  assign after_read = wrap_inc(read_slot_q, eff_size);
  assign free_ext   = SzW'(req_i.free_index);

  always_comb begin
    fill_slot_d  = fill_slot_q;
    next_slot_d  = next_slot_q;
    read_slot_d  = read_slot_q;
    decided_d    = decided_q;
    drop_d       = drop_q;
    first_done_d = first_done_q;
    drop_cnt_d   = drop_cnt_q;
    recv_cnt_d   = recv_cnt_q;
    set_en       = 1'b0;
    free_en      = 1'b0;
    pop_v        = 1'b0;
    pop_idx      = '0;
    seq_err      = 1'b0;
    unique case (req_i.func)
      FUNC_HALF: begin
        // decide once per round
        if (!decided_q) begin
          if (!slot_full_q[after_fill]) begin
            next_slot_d = after_fill;
          end else begin
            drop_d      = 1'b1;
            next_slot_d = fill_slot_q;
          end
          decided_d = 1'b1;
        end
      end
      FUNC_DONE: begin
        if (!decided_q) begin
          seq_err = 1'b1;
        end else if (!dual_channel_i || first_done_q) begin
          if (drop_q) begin
            drop_cnt_d = drop_cnt_q + CountWidth'(1);
          end else begin
            set_en      = 1'b1;
            fill_slot_d = next_slot_q;
            recv_cnt_d  = recv_cnt_q + CountWidth'(1);
          end
          decided_d    = 1'b0;
          drop_d       = 1'b0;
          first_done_d = 1'b0;
        end else begin
          first_done_d = 1'b1;
        end
      end
      FUNC_POP: begin
        if (slot_full_q[read_slot_q]) begin
          pop_v       = 1'b1;
          pop_idx     = read_slot_q;
          read_slot_d = after_read;
        end
      end
      FUNC_FREE: begin
        free_en = free_ext < SzW'(MaxSlots);
      end
      default: ;
    endcase
  end

  // per-slot full flags; a fill and a free never coincide
  always_comb begin
    slot_full_d = slot_full_q;
    for (int i = 0; i < MaxSlots; i++) begin
      if (set_en && fill_slot_q == IdxW'(i)) begin
        slot_full_d[i] = 1'b1;
      end
      if (free_en && free_ext == SzW'(i)) begin
        slot_full_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_full_q  <= '0;
      fill_slot_q  <= '0;
      next_slot_q  <= '0;
      read_slot_q  <= '0;
      decided_q    <= 1'b0;
      drop_q       <= 1'b0;
      first_done_q <= 1'b0;
      drop_cnt_q   <= '0;
      recv_cnt_q   <= '0;
    end else if (fire_i) begin
      slot_full_q  <= slot_full_d;
      fill_slot_q  <= fill_slot_d;
      next_slot_q  <= next_slot_d;
      read_slot_q  <= read_slot_d;
      decided_q    <= decided_d;
      drop_q       <= drop_d;
      first_done_q <= first_done_d;
      drop_cnt_q   <= drop_cnt_d;
      recv_cnt_q   <= recv_cnt_d;
    end
  end

  assign next_ext = OutW'(next_slot_d);
  assign pop_ext  = OutW'(pop_idx);
  assign drop_ext = CntW'(drop_cnt_d);
  assign recv_ext = CntW'(recv_cnt_d);

  always_comb begin
    res_o.next_fill_index = next_ext[INDEX_W-1:0];
    res_o.pop_valid       = pop_v;
    res_o.pop_index       = pop_ext[INDEX_W-1:0];
    res_o.drop_pending    = drop_d;
    res_o.sequence_error  = seq_err;
    res_o.dropped_total   = drop_ext[TOTAL_W-1:0];
    res_o.received_total  = recv_ext[TOTAL_W-1:0];
  end

endmodule

FILE: sv/dma_buffer_ring_manager.sv
// Channel   Dir  Group         Contents (lowest bit first)
// config    in   APB           0x0 ring_size[4:0], 0x4 dual_channel[0]
// events    in   s_axis_*      tuser: func[1:0]; tdata: free_index[3:0], pad
// results   out  m_axis_*      tdata: next_fill_index, pop_valid, pop_index,
//                              drop_pending, sequence_error, dropped_total,
//                              received_total, pad
//
// Flow: one event request per clock while m_axis_tready stays high; a result is
//   presented once its request has passed the input register and then the
//   result register.
// The ring bookkeeping (slot flags, indices, counters) updates in the clock in
//   which a request moves from the input register to the result one.
// Reset: asynchronous, clears all slot flags, indices and counters; ring_size
//   returns to 2, dual_channel to 0.
// Stalls: with m_axis_tready low the result holds and one more request is
//   taken into the input register before s_axis_tready drops.
module dma_buffer_ring_manager import dbrm_pkg::*; #(
  parameter int MaxSlots   = MAX_SLOTS_DEF,
  parameter int CountWidth = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // event requests
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [FUNC_W-1:0]      s_axis_tuser,   // func[1:0]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // free_index[3:0], zeros[7:4]
  // results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // next_fill_index[3:0], pop_valid[4], pop_index[8:5], drop_pending[9],
  // sequence_error[10], dropped_total[42:11], received_total[74:43], zeros[79:75]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  typedef enum logic {
    REG_RING_SIZE    = 1'b0,
    REG_DUAL_CHANNEL = 1'b1
  } reg_e;

  localparam int PadW = OUT_TDATA_W - $bits(result_t);

  logic [RING_SIZE_W-1:0] ring_size_q;
  logic                   dual_channel_q;
  reg_e                   reg_sel;
  logic                   cfg_wr;

  req_t    req;
  logic    fire;
  logic    out_free;
  result_t res;
  result_t res_q;
  logic    m_valid_q;

  // --- configuration port: word index is paddr[2] ---
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q    <= RING_SIZE_RST;
      dual_channel_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_RING_SIZE:    ring_size_q    <= pwdata[RING_SIZE_W-1:0];
        REG_DUAL_CHANNEL: dual_channel_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RING_SIZE:    prdata = 32'(ring_size_q);
      REG_DUAL_CHANNEL: prdata = 32'(dual_channel_q);
      default:          prdata = '0;
    endcase
  end

  // --- input register ---
  dbrm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_user_i   (s_axis_tuser),
    .s_data_i   (s_axis_tdata),
    .s_ready_o  (s_axis_tready),
    .out_free_i (out_free),
    .req_o      (req),
    .fire_o     (fire)
  );

  // --- ring bookkeeping ---
  dbrm_ring_core #(
    .MaxSlots   (MaxSlots),
    .CountWidth (CountWidth)
  ) u_ring_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .fire_i         (fire),
    .ring_size_i    (ring_size_q),
    .dual_channel_i (dual_channel_q),
    .res_o          (res)
  );

  // --- result register ---
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}},
                          res_q.received_total,
                          res_q.dropped_total,
                          res_q.sequence_error,
                          res_q.drop_pending,
                          res_q.pop_index,
                          res_q.pop_valid,
                          res_q.next_fill_index};

endmodule

FILE: sv/dbrm_checker.sv
module dbrm_checker import dbrm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic               out_acc;
  logic [TOTAL_W-1:0] drop_tot, recv_tot;
  logic [TOTAL_W-1:0] prev_drop_q, prev_recv_q;
  logic               pop_v, seq_err;
  logic [INDEX_W-1:0] pop_idx;

  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign pop_v    = m_axis_tdata[4];
  assign pop_idx  = m_axis_tdata[8:5];
  assign seq_err  = m_axis_tdata[10];
  assign drop_tot = m_axis_tdata[42:11];
  assign recv_tot = m_axis_tdata[74:43];

  // totals of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_drop_q <= '0;
      prev_recv_q <= '0;
    end else if (out_acc) begin
      prev_drop_q <= drop_tot;
      prev_recv_q <= recv_tot;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (recv_tot == prev_recv_q || recv_tot == prev_recv_q + TOTAL_W'(1)) &&
                (drop_tot == prev_drop_q || drop_tot == prev_drop_q + TOTAL_W'(1)))
    else $error("counter moved by more than one");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> !(recv_tot != prev_recv_q && drop_tot != prev_drop_q))
    else $error("one event counted as both drop and receive");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seq_err |-> recv_tot == prev_recv_q && drop_tot == prev_drop_q && !pop_v)
    else $error("out-of-order complete changed the counters");

  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !pop_v |-> pop_idx == '0)
    else $error("pop index set without a popped buffer");

endmodule

bind dma_buffer_ring_manager dbrm_checker u_dbrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb_dma_buffer_ring_manager.sv
`timescale 1ns / 100ps

module tb_dma_buffer_ring_manager;
  import dbrm_pkg::*;

  // Register byte addresses on the APB port
  localparam logic [2:0] REG_RING_SIZE = 3'h0;
  localparam logic [2:0] REG_DUAL_CHAN = 3'h4;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PRINT_CAP       = 50;
  // Idle clocks waited after the last result, to cover the idle checks
  localparam int DRAIN_CYCLES    = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [2:0]             paddr   = '0;
  logic [31:0]            pwdata  = '0;
  logic [31:0]            prdata;
  logic                   pready;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [FUNC_W-1:0]      s_axis_tuser  = '0;  // func[1:0]
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // free_index[3:0], zeros[7:4]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // next_fill_index[3:0], pop_valid[4], pop_index[8:5], drop_pending[9],
  // sequence_error[10], dropped_total[42:11], received_total[74:43], zeros[79:75]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  dma_buffer_ring_manager uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Ring shadow: our own copy of the registers and of the bookkeeping state,
  // advanced once per accepted event request.
  // ---------------------------------------------------------------------------
  logic [RING_SIZE_W-1:0] cfg_ring_size = RING_SIZE_RST;
  logic                   cfg_dual      = 1'b0;

  logic               slot_busy [MAX_SLOTS_DEF];
  logic [INDEX_W-1:0] fill_idx;
  logic [INDEX_W-1:0] next_idx;
  logic               round_decided;
  logic               round_drop;
  logic               chan_a_done;
  logic [INDEX_W-1:0] rd_idx;
  logic [TOTAL_W-1:0] drops_seen;
  logic [TOTAL_W-1:0] buffers_seen;

  req_t    event_q[$];          // event requests waiting for the driver
  result_t pending_results[$];  // predicted results, oldest first

  int send_idle = 35;   // percent of cycles the sender holds off
  int recv_idle = 73;   // percent of cycles the receiver stalls
  int errors    = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < MAX_SLOTS_DEF; i++) slot_busy[i] = 1'b0;
    fill_idx      = '0;
    next_idx      = '0;
    round_decided = 1'b0;
    round_drop    = 1'b0;
    chan_a_done   = 1'b0;
    rd_idx        = '0;
    drops_seen    = '0;
    buffers_seen  = '0;
  end

  // Ring size as the block uses it: clamped to MIN_RING_SIZE..MAX_SLOTS
  function automatic logic [RING_SIZE_W-1:0] ring_len();
    logic [RING_SIZE_W-1:0] n;
    n = cfg_ring_size;
    if (n < RING_SIZE_W'(MIN_RING_SIZE)) n = RING_SIZE_W'(MIN_RING_SIZE);
    if (n > RING_SIZE_W'(MAX_SLOTS_DEF)) n = RING_SIZE_W'(MAX_SLOTS_DEF);
    return n;
  endfunction

  // Index + 1, wrapping at the ring size (also pulls stale indices back in)
  function automatic logic [INDEX_W-1:0] ring_next(logic [INDEX_W-1:0] x);
    logic [RING_SIZE_W-1:0] y;
    y = {1'b0, x} + RING_SIZE_W'(1);
    return (y >= ring_len()) ? '0 : y[INDEX_W-1:0];
  endfunction

  task automatic advance_ring(req_t ev);
    result_t r;
    logic [INDEX_W-1:0] after;
    r = '0;
    case (ev.func)
      FUNC_HALF: begin
        // only the first half-complete of a round decides
        if (!round_decided) begin
          after = ring_next(fill_idx);
          if (!slot_busy[after]) begin
            next_idx = after;
          end else begin
            round_drop = 1'b1;
            next_idx   = fill_idx;
          end
          round_decided = 1'b1;
        end
      end
      FUNC_DONE: begin
        if (!round_decided) begin
          r.sequence_error = 1'b1;
        end else if (!cfg_dual || chan_a_done) begin
          if (round_drop) begin
            drops_seen = drops_seen + 1'b1;
          end else begin
            slot_busy[fill_idx] = 1'b1;
            fill_idx     = next_idx;
            buffers_seen = buffers_seen + 1'b1;
          end
          round_decided = 1'b0;
          round_drop    = 1'b0;
          chan_a_done   = 1'b0;
        end else begin
          chan_a_done = 1'b1;
        end
      end
      FUNC_POP: begin
        if (slot_busy[rd_idx]) begin
          r.pop_valid = 1'b1;
          r.pop_index = rd_idx;
          rd_idx      = ring_next(rd_idx);
        end
      end
      default: begin
        slot_busy[ev.free_index] = 1'b0;
      end
    endcase
    r.next_fill_index = next_idx;
    r.drop_pending    = round_drop;
    r.dropped_total   = drops_seen;
    r.received_total  = buffers_seen;
    pending_results.push_back(r);
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one request in flight on s_axis, held until accepted. A new one is
  // loaded only when the slot is empty or was just taken, so tvalid gets one
  // assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      req_t taken;
      req_t nxt;
      if (s_axis_tvalid) begin
        taken.func       = func_e'(s_axis_tuser);
        taken.free_index = s_axis_tdata[INDEX_W-1:0];
        advance_ring(taken);
      end
      if (event_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = event_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.func;
        s_axis_tdata  <= {{(IN_TDATA_W-INDEX_W){1'b0}}, nxt.free_index};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction, then
  // pick the stall for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      result_t want;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result", m_axis_tdata[31:0], 0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[3:0] !== want.next_fill_index)
            flag_mismatch("next_fill_index", m_axis_tdata[3:0], want.next_fill_index);
          if (m_axis_tdata[4] !== want.pop_valid)
            flag_mismatch("pop_valid", m_axis_tdata[4], want.pop_valid);
          if (m_axis_tdata[8:5] !== want.pop_index)
            flag_mismatch("pop_index", m_axis_tdata[8:5], want.pop_index);
          if (m_axis_tdata[9] !== want.drop_pending)
            flag_mismatch("drop_pending", m_axis_tdata[9], want.drop_pending);
          if (m_axis_tdata[10] !== want.sequence_error)
            flag_mismatch("sequence_error", m_axis_tdata[10], want.sequence_error);
          if (m_axis_tdata[42:11] !== want.dropped_total)
            flag_mismatch("dropped_total", m_axis_tdata[42:11], want.dropped_total);
          if (m_axis_tdata[74:43] !== want.received_total)
            flag_mismatch("received_total", m_axis_tdata[74:43], want.received_total);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_ev(func_e f, logic [INDEX_W-1:0] idx);
    req_t ev;
    ev.func       = f;
    ev.free_index = idx;
    event_q.push_back(ev);
  endtask

  // Setup then access; the shadow register follows the same write
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_RING_SIZE) cfg_ring_size = data[RING_SIZE_W-1:0];
    else if (addr == REG_DUAL_CHAN) cfg_dual = data[0];
  endtask

  // Block is idle once every request went out and every result came back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (event_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Consumer side: pop in ring order, or free a slot (mostly inside the ring)
  task automatic consumer_ev(int len);
    if ($urandom_range(1) == 0)
      push_ev(FUNC_POP, INDEX_W'($urandom_range(15)));
    else if ($urandom_range(3) != 0)
      push_ev(FUNC_FREE, INDEX_W'($urandom_range(len - 1)));
    else
      push_ev(FUNC_FREE, INDEX_W'($urandom_range(15)));
  endtask

  // One DMA round with consumer traffic around it, or a burst of noise
  task automatic gen_round(int len, logic dual, output int n);
    int k;
    n = 0;
    if ($urandom_range(9) < 8) begin
      k = $urandom_range(2);
      repeat (k) consumer_ev(len);
      n += k;
      push_ev(FUNC_HALF, INDEX_W'($urandom_range(15)));
      n++;
      if ($urandom_range(3) == 0) begin
        push_ev(FUNC_HALF, INDEX_W'($urandom_range(15)));
        n++;
      end
      k = $urandom_range(2);
      repeat (k) consumer_ev(len);
      n += k;
      push_ev(FUNC_DONE, INDEX_W'($urandom_range(15)));
      n++;
      if (dual) begin
        push_ev(FUNC_DONE, INDEX_W'($urandom_range(15)));
        n++;
      end
    end else begin
      k = $urandom_range(3, 1);
      repeat (k) push_ev(func_e'($urandom_range(3)), INDEX_W'($urandom_range(15)));
      n += k;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // ring sizes cover below range, both extremes and above range
    int ring_tab [PHASES] = '{5, 16, 3, 31, 1, 2, 16, 7};
    int dual_tab [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};
    int len;
    int made;
    int n;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_write(REG_RING_SIZE, 32'd2);
    apb_write(REG_DUAL_CHAN, 32'd0);

    // Directed, ring of two, single channel
    push_ev(FUNC_DONE, 4'hF);   // complete with nothing decided: sequence error
    push_ev(FUNC_POP,  4'h0);   // pop on an empty ring
    push_ev(FUNC_HALF, 4'h5);   // decide: slot 1
    push_ev(FUNC_HALF, 4'hA);   // repeated half complete, no change
    push_ev(FUNC_DONE, 4'h0);   // slot 0 full, fill moves to 1
    push_ev(FUNC_HALF, 4'h3);   // slot 0 still full: drop round
    push_ev(FUNC_DONE, 4'hC);   // drop counted
    push_ev(FUNC_POP,  4'h0);   // pops slot 0
    push_ev(FUNC_POP,  4'h9);   // slot 1 not full yet
    push_ev(FUNC_FREE, 4'h0);
    push_ev(FUNC_FREE, 4'hF);   // index beyond the ring is still cleared
    push_ev(FUNC_HALF, 4'h6);
    push_ev(FUNC_DONE, 4'h7);
    push_ev(FUNC_POP,  4'hE);
    wait_idle();

    // Directed, ring size below range with both channels
    apb_write(REG_RING_SIZE, 32'd0);
    apb_write(REG_DUAL_CHAN, 32'd1);
    push_ev(FUNC_HALF, 4'h0);
    push_ev(FUNC_DONE, 4'hF);   // first channel only
    push_ev(FUNC_DONE, 4'h8);   // second channel closes the round
    push_ev(FUNC_DONE, 4'h1);   // sequence error
    push_ev(FUNC_HALF, 4'h2);
    push_ev(FUNC_DONE, 4'h4);
    push_ev(FUNC_HALF, 4'hB);   // ignored, round already decided
    push_ev(FUNC_DONE, 4'hD);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle = 35;
        recv_idle = 73;
      end else if (p < 6) begin
        send_idle = 73;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      apb_write(REG_RING_SIZE, ring_tab[p]);
      apb_write(REG_DUAL_CHAN, dual_tab[p]);
      len = (ring_tab[p] < MIN_RING_SIZE) ? MIN_RING_SIZE :
            (ring_tab[p] > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : ring_tab[p];
      made = 0;
      while (made < ITEMS_PER_PHASE / 2) begin
        gen_round(len, dual_tab[p][0], n);
        made += n;
      end
      // sender holds off until every result is back
      wait_idle();
      while (made < ITEMS_PER_PHASE) begin
        gen_round(len, dual_tab[p][0], n);
        made += n;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/dbrm_pkg.sv
sv/dbrm_in_stage.sv
sv/dbrm_ring_core.sv
sv/dma_buffer_ring_manager.sv
sv/dbrm_checker.sv
tb/tb_dma_buffer_ring_manager.sv
